// ===== hdl/nsb_pkg.sv =====
// Shared types and constants for the nibble sprite blitter.
// No dependencies; imported by nibble_sprite_blitter.
package nsb_pkg;

    // Memory sizes are powers of two: addresses wrap by truncation.
    localparam int VRAM_DEPTH = 32768;
    localparam int ROM_DEPTH  = 65536;
    localparam int BLIT_ROWS  = 16;
    localparam int BLIT_BYTES = 8;
    localparam int ROW_PITCH  = 128;

    localparam int VRAM_AW = $clog2(VRAM_DEPTH);
    localparam int ROM_AW  = $clog2(ROM_DEPTH);
    // wide enough for any base address plus any step before wrapping
    localparam int SUM_W   = 18;
    localparam int COL_W   = (BLIT_BYTES > 1) ? $clog2(BLIT_BYTES) : 1;
    localparam int ROW_W   = (BLIT_ROWS > 1) ? $clog2(BLIT_ROWS) : 1;

    localparam logic [7:0] MASK_HI = 8'hF0;
    localparam logic [7:0] MASK_LO = 8'h0F;

    typedef enum logic [1:0] {
        OP_REG_WR  = 2'd0,
        OP_VRAM_WR = 2'd1,
        OP_VRAM_RD = 2'd2,
        OP_ROM_LD  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_DST_HI = 2'd0,
        REG_DST_LO = 2'd1,
        REG_SRC_HI = 2'd2,
        REG_SRC_LO = 2'd3
    } reg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_BLIT_RD,
        ST_BLIT_WR
    } state_t;

endpackage

// ===== hdl/nibble_sprite_blitter.sv =====
// Nibble sprite blitter: video RAM, graphics ROM and a 16 x 8 byte blit engine.
// Depends on nsb_pkg.
//
//  channel | signals                                       | direction
//  --------+-----------------------------------------------+----------
//  in      | in_valid in_ready op reg_index vram_addr      | to block
//          | rom_addr data                                 |
//  out     | out_valid out_ready read_data blit_ran        | from block
//
// Register, video write and ROM load beats are answered from the idle state; a video
// read is answered from a read state. A blit reads ROM and video in a read state, then
// writes back in a write state for each byte, set by the single video RAM port.
// rst_n clears the blitter registers and control; the memories are not cleared.
// A result waits in the output register; a new beat is taken in the cycle it leaves.
module nibble_sprite_blitter (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  nsb_pkg::op_t         op,
    input  logic [1:0]           reg_index,
    input  logic [14:0]          vram_addr,
    input  logic [15:0]          rom_addr,
    input  logic [7:0]           data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [7:0]           read_data,
    output logic                 blit_ran
);
    import nsb_pkg::*;

    state_t               state_reg, state_next;
    logic [7:0]           regs_reg [4];
    logic                 draw_reg, draw_next;
    logic [ROM_AW-1:0]    src_row_reg, src_row_next;
    logic [VRAM_AW-1:0]   dst_row_reg, dst_row_next;
    logic [COL_W-1:0]     col_reg, col_next;
    logic [ROW_W-1:0]     row_reg, row_next;
    logic                 out_valid_reg, out_valid_next;
    logic [7:0]           read_data_reg, read_data_next;
    logic                 blit_ran_reg, blit_ran_next;

    logic [7:0]           vram_mem [VRAM_DEPTH];
    logic [7:0]           rom_mem [ROM_DEPTH];
    logic [7:0]           vram_q, rom_q;
    logic                 vram_we, vram_re, rom_we, rom_re;
    logic [VRAM_AW-1:0]   vram_a;
    logic [ROM_AW-1:0]    rom_a;
    logic [7:0]           vram_wd, rom_wd;

    logic                 accept, trigger, col_last, row_last;
    logic [15:0]          src_word, dst_word;
    logic [SUM_W-1:0]     vsum, rsum, vin_sum, rin_sum, src_base, dst_base;
    logic [SUM_W-1:0]     src_step, dst_step;
    logic [7:0]           clr_val;

    assign in_ready = (state_reg == ST_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign trigger  = (op == OP_REG_WR) && (reg_index == REG_SRC_LO);
    assign col_last = (col_reg == COL_W'(BLIT_BYTES - 1));
    assign row_last = (row_reg == ROW_W'(BLIT_ROWS - 1));

    // blit base addresses; the trigger beat supplies the low source byte
    assign src_word = {regs_reg[REG_SRC_HI], data};
    assign dst_word = {regs_reg[REG_DST_HI], regs_reg[REG_DST_LO]};
    assign src_base = SUM_W'({src_word[15:2], 1'b0});
    assign dst_base = SUM_W'(dst_word[15:1]);

    assign vsum     = SUM_W'(dst_row_reg) + SUM_W'(col_reg);
    assign rsum     = SUM_W'(src_row_reg) + SUM_W'(col_reg);
    assign vin_sum  = SUM_W'(vram_addr);
    assign rin_sum  = SUM_W'(rom_addr);
    assign src_step = SUM_W'(src_row_reg) + SUM_W'(BLIT_BYTES);
    assign dst_step = SUM_W'(dst_row_reg) + SUM_W'(ROW_PITCH);

    // clear mode: each non-zero source nibble clears the opposite video nibble, where draw mode would put it
    always_comb
    begin
        clr_val = vram_q;
        if ((rom_q & MASK_HI) != 8'd0)
            clr_val = clr_val & MASK_HI;
        if ((rom_q & MASK_LO) != 8'd0)
            clr_val = clr_val & MASK_LO;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && op == OP_VRAM_RD)
                    state_next = ST_READ;
                else if (accept && trigger)
                    state_next = ST_BLIT_RD;
            end
            ST_READ:    state_next = ST_IDLE;
            ST_BLIT_RD: state_next = ST_BLIT_WR;
            ST_BLIT_WR: state_next = (col_last && row_last) ? ST_IDLE : ST_BLIT_RD;
            default:    state_next = ST_IDLE;
        endcase
    end

    // memory controls and datapath updates
    always_comb
    begin
        vram_we        = 1'b0;
        vram_re        = 1'b0;
        vram_wd        = data;
        vram_a         = vin_sum[VRAM_AW-1:0];
        rom_we         = 1'b0;
        rom_re         = 1'b0;
        rom_wd         = data;
        rom_a          = rin_sum[ROM_AW-1:0];
        draw_next      = draw_reg;
        src_row_next   = src_row_reg;
        dst_row_next   = dst_row_reg;
        col_next       = col_reg;
        row_next       = row_reg;
        out_valid_next = out_valid_reg && !out_ready;
        read_data_next = read_data_reg;
        blit_ran_next  = blit_ran_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    case (op)
                        OP_REG_WR:
                        begin
                            if (!trigger)
                            begin
                                out_valid_next = 1'b1;
                                read_data_next = 8'd0;
                                blit_ran_next  = 1'b0;
                            end
                            draw_next    = src_word[0];
                            src_row_next = src_base[ROM_AW-1:0];
                            dst_row_next = dst_base[VRAM_AW-1:0];
                            col_next     = '0;
                            row_next     = '0;
                        end
                        OP_VRAM_WR:
                        begin
                            vram_we        = 1'b1;
                            out_valid_next = 1'b1;
                            read_data_next = 8'd0;
                            blit_ran_next  = 1'b0;
                        end
                        OP_VRAM_RD:
                        begin
                            vram_re = 1'b1;
                        end
                        OP_ROM_LD:
                        begin
                            rom_we         = 1'b1;
                            out_valid_next = 1'b1;
                            read_data_next = 8'd0;
                            blit_ran_next  = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ:
            begin
                out_valid_next = 1'b1;
                read_data_next = vram_q;
                blit_ran_next  = 1'b0;
            end
            ST_BLIT_RD:
            begin
                vram_a  = vsum[VRAM_AW-1:0];
                rom_a   = rsum[ROM_AW-1:0];
                vram_re = 1'b1;
                rom_re  = 1'b1;
            end
            ST_BLIT_WR:
            begin
                vram_a  = vsum[VRAM_AW-1:0];
                vram_we = (rom_q != 8'd0);
                vram_wd = draw_reg ? {rom_q[3:0], rom_q[7:4]} : clr_val;
                if (col_last)
                begin
                    col_next     = '0;
                    row_next     = row_reg + ROW_W'(1);
                    src_row_next = src_step[ROM_AW-1:0];
                    dst_row_next = dst_step[VRAM_AW-1:0];
                    if (row_last)
                    begin
                        out_valid_next = 1'b1;
                        read_data_next = 8'd0;
                        blit_ran_next  = 1'b1;
                    end
                end
                else
                    col_next = col_reg + COL_W'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++)
                regs_reg[i] <= 8'd0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (accept && op == OP_REG_WR)
                regs_reg[reg_index] <= data;
        end
    end

    always_ff @(posedge clk)
    begin
        draw_reg      <= draw_next;
        src_row_reg   <= src_row_next;
        dst_row_reg   <= dst_row_next;
        col_reg       <= col_next;
        row_reg       <= row_next;
        read_data_reg <= read_data_next;
        blit_ran_reg  <= blit_ran_next;
    end

    always_ff @(posedge clk)
    begin
        if (vram_we)
            vram_mem[vram_a] <= vram_wd;
        if (vram_re)
            vram_q <= vram_mem[vram_a];
    end

    always_ff @(posedge clk)
    begin
        if (rom_we)
            rom_mem[rom_a] <= rom_wd;
        if (rom_re)
            rom_q <= rom_mem[rom_a];
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign blit_ran  = blit_ran_reg;

`ifndef SYNTH
    a_trigger_starts_blit: assert property (@(posedge clk) disable iff (!rst_n)
        accept && trigger |=> state_reg == ST_BLIT_RD)
        else $error("trigger beat did not start a blit");

    a_no_result_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != ST_IDLE |-> !out_valid_reg)
        else $error("result pending while a read or blit is in progress");

    a_blit_result_from_last_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) && blit_ran_reg |-> $past(state_reg) == ST_BLIT_WR)
        else $error("blit result not produced by the final write-back");

    a_no_vram_write_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_READ || state_reg == ST_BLIT_RD |-> !vram_we)
        else $error("video RAM written during a read cycle");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_BLIT_WR |-> col_reg <= COL_W'(BLIT_BYTES - 1))
        else $error("blit column counter out of range");
`endif

endmodule

// ===== tb/sv/nibble_sprite_blitter_test.sv =====
// Self-checking testbench for nibble_sprite_blitter: a mirror of the blitter registers,
// video RAM and graphics ROM predicts each result beat and checks it in order.
// Depends on nsb_pkg and the nibble_sprite_blitter RTL.
`timescale 1ns / 100ps

module nibble_sprite_blitter_test;

    import nsb_pkg::*;

    typedef struct packed {
        logic [7:0] read_data;
        logic       blit_ran;
    } readback_t;

    class blitter_mirror;
        bit [7:0]  regs [4];
        bit [7:0]  vram [VRAM_DEPTH];
        bit        vram_set [VRAM_DEPTH];
        bit [7:0]  rom [ROM_DEPTH];
        bit        rom_set [ROM_DEPTH];
        int        vram_live [$];      // video addresses holding a known byte
        readback_t due [$];
        int        mismatches;

        function int src_of(logic [15:0] word);
            return int'((word >> 1) & 16'h7FFE);
        endfunction

        function int dst_of(logic [15:0] word);
            return int'((word >> 1) & 16'h7FFF);
        endfunction

        function void poke_vram(int a, bit [7:0] v);
            vram[a] = v;
            if (!vram_set[a])
            begin
                vram_set[a] = 1'b1;
                vram_live.push_back(a);
            end
        endfunction

        function void run_sprite_blit();
            int       src;
            int       dst;
            int       a;
            bit       draw;
            bit [7:0] b;
            draw = regs[REG_SRC_LO][0];
            src  = src_of({regs[REG_SRC_HI], regs[REG_SRC_LO]});
            dst  = dst_of({regs[REG_DST_HI], regs[REG_DST_LO]});
            for (int r = 0; r < BLIT_ROWS; r++)
            begin
                for (int c = 0; c < BLIT_BYTES; c++)
                begin
                    b = rom[(src + r * BLIT_BYTES + c) % ROM_DEPTH];
                    a = (dst + r * ROW_PITCH + c) % VRAM_DEPTH;
                    if (draw)
                    begin
                        if (b != 8'h00)
                            poke_vram(a, {b[3:0], b[7:4]});
                    end
                    else
                    begin
                        // high ROM nibble lands on the low screen nibble and vice versa
                        if (b[7:4] != 4'h0)
                            vram[a] = vram[a] & 8'hF0;
                        if (b[3:0] != 4'h0)
                            vram[a] = vram[a] & 8'h0F;
                    end
                end
            end
        endfunction

        function void note_beat(op_t kind, logic [1:0] idx, logic [14:0] va,
                                logic [15:0] ra, logic [7:0] d);
            readback_t res;
            res = '0;
            case (kind)
                OP_REG_WR:
                begin
                    regs[idx] = d;
                    if (idx == REG_SRC_LO)
                    begin
                        run_sprite_blit();
                        res.blit_ran = 1'b1;
                    end
                end
                OP_VRAM_WR: poke_vram(va, d);
                OP_VRAM_RD: res.read_data = vram[va];
                default:
                begin
                    rom[ra]     = d;
                    rom_set[ra] = 1'b1;
                end
            endcase
            due.push_back(res);
        endfunction

        function void check_beat(logic [7:0] rd, logic ran);
            readback_t want;
            if (due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("result beat with nothing pending: read_data=%02h blit_ran=%0b",
                             rd, ran);
                return;
            end
            want = due.pop_front();
            if (rd !== want.read_data || ran !== want.blit_ran)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected read_data=%02h blit_ran=%0b, got %02h %0b",
                             want.read_data, want.blit_ran, rd, ran);
            end
        endfunction
    endclass

    localparam int CYCLE_LIMIT  = 3000000;
    localparam int RANDOM_BEATS = 1460;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    op_t         op;
    logic [1:0]  reg_index;
    logic [14:0] vram_addr;
    logic [15:0] rom_addr;
    logic [7:0]  data;
    logic        out_valid;
    logic        out_ready;
    logic [7:0]  read_data;
    logic        blit_ran;

    blitter_mirror mirror;
    int            beats_sent;
    int            cycles = 0;
    bit            calm;

    nibble_sprite_blitter dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .reg_index (reg_index),
        .vram_addr (vram_addr),
        .rom_addr  (rom_addr),
        .data      (data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .read_data (read_data),
        .blit_ran  (blit_ran)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("** nibble_sprite_blitter: FAILED **");
            $finish;
        end
    end

    // Result side: random stall bursts, no new ones once the run goes calm.
    initial
    begin : result_sink
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
                mirror.check_beat(read_data, blit_ran);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                hold = $urandom_range(0, 12);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    function automatic logic [1:0] rand_idx();
        return 2'($urandom);
    endfunction

    function automatic logic [14:0] rand_va();
        return 15'($urandom);
    endfunction

    function automatic logic [15:0] rand_ra();
        return 16'($urandom);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom);
    endfunction

    function automatic logic [7:0] sprite_byte();
        logic [3:0] n;
        n = 4'($urandom_range(1, 15));
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return {n, 4'h0};
            2:       return {4'h0, n};
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [14:0] tile_addr(int dst, int r, int c);
        return 15'((dst + r * ROW_PITCH + c) % VRAM_DEPTH);
    endfunction

    // valid stays up across back-to-back beats; it only drops for an idle burst
    task automatic send_beat(input op_t kind, input logic [1:0] idx, input logic [14:0] va,
                             input logic [15:0] ra, input logic [7:0] d);
        int gap;
        gap = (!calm && $urandom_range(0, 7) == 0) ? $urandom_range(1, 13) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op        <= kind;
        reg_index <= idx;
        vram_addr <= va;
        rom_addr  <= ra;
        data      <= d;
        in_valid  <= 1'b1;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        mirror.note_beat(kind, idx, va, ra, d);
        beats_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (mirror.due.size() != 0)
            @(posedge clk);
    endtask

    // Every ROM byte and screen byte a blit touches must hold a known value first.
    task automatic cover_footprint(input int src, input int dst);
        logic [15:0] ra;
        logic [14:0] va;
        for (int k = 0; k < BLIT_ROWS * BLIT_BYTES; k++)
        begin
            ra = 16'((src + k) % ROM_DEPTH);
            if (!mirror.rom_set[ra])
                send_beat(OP_ROM_LD, rand_idx(), rand_va(), ra, sprite_byte());
        end
        for (int r = 0; r < BLIT_ROWS; r++)
        begin
            for (int c = 0; c < BLIT_BYTES; c++)
            begin
                va = tile_addr(dst, r, c);
                if (!mirror.vram_set[va])
                    send_beat(OP_VRAM_WR, rand_idx(), va, rand_ra(), rand_byte());
            end
        end
    endtask

    task automatic launch_blit(input logic [15:0] dst_word, input logic [15:0] src_word,
                               input bit keep_dst, input bit keep_src);
        int src;
        int dst;
        if (!keep_dst)
        begin
            send_beat(OP_REG_WR, REG_DST_HI, rand_va(), rand_ra(), dst_word[15:8]);
            send_beat(OP_REG_WR, REG_DST_LO, rand_va(), rand_ra(), dst_word[7:0]);
        end
        if (!keep_src)
            send_beat(OP_REG_WR, REG_SRC_HI, rand_va(), rand_ra(), src_word[15:8]);
        src = mirror.src_of({mirror.regs[REG_SRC_HI], src_word[7:0]});
        dst = mirror.dst_of({mirror.regs[REG_DST_HI], mirror.regs[REG_DST_LO]});
        cover_footprint(src, dst);
        repeat ($urandom_range(0, 3))
        begin
            if ($urandom_range(0, 1))
                send_beat(OP_ROM_LD, rand_idx(), rand_va(),
                          16'((src + $urandom_range(0, BLIT_ROWS * BLIT_BYTES - 1))
                              % ROM_DEPTH),
                          sprite_byte());
            else
                send_beat(OP_VRAM_WR, rand_idx(),
                          tile_addr(dst, $urandom_range(0, BLIT_ROWS - 1),
                                    $urandom_range(0, BLIT_BYTES - 1)),
                          rand_ra(), rand_byte());
        end
        send_beat(OP_REG_WR, REG_SRC_LO, rand_va(), rand_ra(), src_word[7:0]);
        repeat ($urandom_range(1, 4))
            send_beat(OP_VRAM_RD, rand_idx(),
                      tile_addr(dst, $urandom_range(0, BLIT_ROWS - 1),
                                $urandom_range(0, BLIT_BYTES - 1)),
                      rand_ra(), rand_byte());
    endtask

    initial
    begin : stimulus
        int          target;
        int          pick;
        int          src;
        int          dst;
        bit          paused;
        logic [7:0]  d;
        mirror     = new();
        beats_sent = 0;
        calm       = 1'b0;
        paused     = 1'b0;
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        op        <= OP_REG_WR;
        reg_index <= REG_DST_HI;
        vram_addr <= '0;
        rom_addr  <= '0;
        data      <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: address and data extremes, every op
        send_beat(OP_ROM_LD,  REG_DST_HI, 15'h7FFF, 16'h0000, 8'hFF);
        send_beat(OP_ROM_LD,  REG_SRC_LO, 15'h0000, 16'hFFFF, 8'h00);
        send_beat(OP_VRAM_WR, REG_DST_HI, 15'h0000, 16'hFFFF, 8'hFF);
        send_beat(OP_VRAM_WR, REG_SRC_LO, 15'h7FFF, 16'h0000, 8'h00);
        send_beat(OP_VRAM_WR, REG_SRC_HI, 15'h5555, 16'hAAAA, 8'hA5);
        send_beat(OP_VRAM_RD, REG_DST_LO, 15'h0000, 16'hFFFF, 8'hFF);
        send_beat(OP_VRAM_RD, REG_DST_HI, 15'h7FFF, 16'h0000, 8'h00);
        send_beat(OP_VRAM_RD, REG_SRC_LO, 15'h5555, 16'h5555, 8'h5A);
        send_beat(OP_REG_WR,  REG_DST_HI, 15'h2AAA, 16'h0F0F, 8'hFF);
        send_beat(OP_REG_WR,  REG_DST_LO, 15'h1234, 16'hF0F0, 8'h00);
        send_beat(OP_REG_WR,  REG_SRC_HI, 15'h4321, 16'h8001, 8'hFF);
        launch_blit(16'h0000, 16'h0001, 1'b0, 1'b0);   // draw from ROM 0 to screen 0
        launch_blit(16'h0000, 16'h0000, 1'b0, 1'b0);   // clear the same tiles
        launch_blit(16'hFFFF, 16'hFFFF, 1'b0, 1'b0);   // top of screen: rows wrap to 0
        launch_blit(16'hFFFF, 16'hFFFE, 1'b1, 1'b1);   // clear, stale high registers
        drain();

        target = beats_sent + RANDOM_BEATS;
        while (beats_sent < target)
        begin
            if (beats_sent > target - 200)
                calm = 1'b1;
            if (!paused && beats_sent > target - RANDOM_BEATS / 2)
            begin
                drain();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 55)
            begin
                // mostly small windows at both ends so footprints are reused
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    dst = $urandom_range(0, 7);
                else if (pick < 97)
                    dst = 16'h7FFC + $urandom_range(0, 3);
                else
                    dst = $urandom_range(0, 16'h7FFF);
                pick = $urandom_range(0, 99);
                if (pick < 45)
                    src = 2 * $urandom_range(0, 8);
                else if (pick < 97)
                    src = 16'h7FE0 + 2 * $urandom_range(0, 15);
                else
                    src = $urandom_range(0, 16'h7FFF) & 16'h7FFE;
                launch_blit(16'((dst << 1) | $urandom_range(0, 1)),
                            16'((src << 1) | ($urandom_range(0, 1) << 1)
                                | $urandom_range(0, 1)),
                            $urandom_range(0, 99) < 15, $urandom_range(0, 99) < 15);
            end
            else
            begin
                pick = $urandom_range(0, 99);
                d    = rand_byte();
                if (pick < 25)
                    send_beat(OP_ROM_LD, rand_idx(), rand_va(), rand_ra(), d);
                else if (pick < 50)
                    send_beat(OP_VRAM_WR, rand_idx(), rand_va(), rand_ra(), d);
                else if (pick < 75)
                    send_beat(OP_VRAM_RD, rand_idx(),
                              15'(mirror.vram_live[$urandom_range(0,
                                  mirror.vram_live.size() - 1)]),
                              rand_ra(), d);
                else if (pick < 97)
                    send_beat(OP_REG_WR, 2'($urandom_range(0, 2)), rand_va(), rand_ra(), d);
                else
                    launch_blit('0, {8'h00, d}, 1'b1, 1'b1);   // whatever the registers hold
            end
        end

        in_valid <= 1'b0;
        drain();
        repeat (300) @(posedge clk);
        if (mirror.mismatches == 0 && mirror.due.size() == 0)
            $display("** nibble_sprite_blitter: PASSED **");
        else
            $display("** nibble_sprite_blitter: FAILED **");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/nsb_pkg.sv
hdl/nibble_sprite_blitter.sv
tb/sv/nibble_sprite_blitter_test.sv
